FILE: rtl/core/int8_dot_product_dequant_defines.svh
// Assertion macros shared by the INT8 dot product block.
`ifndef INT8_DOT_PRODUCT_DEQUANT_DEFINES_SVH
`define INT8_DOT_PRODUCT_DEQUANT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IDPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define IDPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/core/idpd_pkg.sv
// Package with constants and types for the INT8 dot product block.
package idpd_pkg;

  localparam int LANES      = 4;
  localparam int PACK_LANES = 4;
  localparam int EFF_LANES  = (LANES < PACK_LANES) ? LANES : PACK_LANES;

  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  localparam logic [31:0] ALPHA_RESET = 32'h0100_0000;
  localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

  typedef struct packed {
    logic        pend;
    logic        done;
    logic [31:0] dot;
  } idpd_dot_stat_t;

  typedef struct packed {
    logic [31:0] row_scale;
    logic [31:0] col_scale;
    logic [31:0] c_prev;
    logic [31:0] alpha_gain;
    logic [31:0] beta_gain;
  } idpd_opnd_t;

  typedef struct packed {
    logic [31:0] dequant_out;
    logic [31:0] raw_dot;
    logic        saturated;
  } idpd_res_t;

endpackage

FILE: rtl/core/idpd_in_if.sv
// Input channel interface carrying packed byte pairs and scales.
interface idpd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_pack;
  logic [31:0] b_pack;
  logic [2:0]  lanes_used;
  logic        last_item;
  logic [31:0] row_scale;
  logic [31:0] col_scale;
  logic signed [31:0] c_prev;

  modport source (
    output valid, a_pack, b_pack, lanes_used, last_item, row_scale, col_scale, c_prev,
    input  ready
  );
  modport sink (
    input  valid, a_pack, b_pack, lanes_used, last_item, row_scale, col_scale, c_prev,
    output ready
  );
endinterface

FILE: rtl/core/idpd_out_if.sv
// Output channel interface carrying the dequantized result.
interface idpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dequant_out;
  logic signed [31:0] raw_dot;
  logic               saturated;

  modport source (
    output valid, dequant_out, raw_dot, saturated,
    input  ready
  );
  modport sink (
    input  valid, dequant_out, raw_dot, saturated,
    output ready
  );
endinterface

FILE: rtl/core/idpd_lane.sv
// One multiplier lane: registered signed byte product.
module idpd_lane
  import idpd_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               active,
  input  logic signed [7:0]  a_byte,
  input  logic signed [7:0]  b_byte,
  output logic signed [15:0] prod
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= active ? (a_byte * b_byte) : 16'sd0;
    end
  end

endmodule

FILE: rtl/core/idpd_dot.sv
// Parallel byte lanes, merging adder and the wrapping dot product accumulator.
module idpd_dot
  import idpd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [31:0]    a_pack,
  input  logic [31:0]    b_pack,
  input  logic [2:0]     lanes_used,
  input  logic           last_item,
  output idpd_dot_stat_t stat
);

  logic signed [15:0] prod [EFF_LANES];
  logic               v1;
  logic               last1;
  logic [31:0]        acc;
  logic [31:0]        merged;
  logic [31:0]        acc_next;
  logic               done;
  logic [31:0]        dot;

  for (genvar i = 0; i < EFF_LANES; i++) begin : g_lane
    idpd_lane u_lane (
      .clk    (clk),
      .load   (load),
      .active (lanes_used > 3'(i)),
      .a_byte (a_pack[8*i +: 8]),
      .b_byte (b_pack[8*i +: 8]),
      .prod   (prod[i])
    );
  end

  always_comb begin
    merged = '0;
    for (int i = 0; i < EFF_LANES; i++) begin
      merged = merged + 32'(prod[i]);
    end
    acc_next = acc + merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      acc  <= '0;
      done <= 1'b0;
    end else begin
      v1   <= load;
      done <= v1 && last1;
      if (v1) begin
        acc <= last1 ? 32'd0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last1 <= last_item;
    end
    if (v1 && last1) begin
      dot <= acc_next;
    end
  end

  assign stat.pend = (v1 && last1) || done;
  assign stat.done = done;
  assign stat.dot  = dot;

endmodule

FILE: rtl/core/idpd_dequant.sv
// Dequantization sequencer built around one shared 32 by 32 bit multiplier.
module idpd_dequant
  import idpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dot,
  input  idpd_opnd_t  opnd,
  output logic        idle,
  output logic        res_valid,
  input  logic        res_ready,
  output idpd_res_t   res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_BETA = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_SAT  = 3'd5;

  localparam logic [3:0]   MUL_LAST   = 4'd11;
  localparam logic [127:0] ROUND_HALF = 128'd1 << 55;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  logic [2:0]   state;
  logic [3:0]   cnt;
  logic [127:0] x;
  logic [31:0]  carry;
  logic         neg;
  logic         bneg;
  logic [63:0]  bp;
  logic [64:0]  bt;
  logic [31:0]  dot_q;
  logic [31:0]  m_sel;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  prod;
  logic [63:0]  mac;
  logic         fits;
  logic         out_free;

  always_comb begin
    case (cnt[3:2])
      2'd0:    m_sel = opnd.row_scale;
      2'd1:    m_sel = opnd.col_scale;
      default: m_sel = mag32(opnd.alpha_gain);
    endcase
    mul_a = (state == S_MUL) ? x[31:0] : mag32(opnd.beta_gain);
    mul_b = (state == S_MUL) ? m_sel : mag32(opnd.c_prev);
    prod  = {32'd0, mul_a} * {32'd0, mul_b};
    mac   = prod + {32'd0, carry};
    fits  = (x[127:87] == {41{x[127]}});
  end

  assign idle     = (state == S_IDLE);
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if ((state == S_SAT) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt == MUL_LAST) begin
            state <= S_BETA;
          end
        end
        S_BETA: state <= S_SIGN;
        S_SIGN: state <= S_ADD;
        S_ADD:  state <= S_SAT;
        S_SAT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          x     <= {96'd0, mag32(dot)};
          neg   <= dot[31] ^ opnd.alpha_gain[31];
          bneg  <= opnd.beta_gain[31] ^ opnd.c_prev[31];
          carry <= '0;
          cnt   <= '0;
          dot_q <= dot;
        end
      end
      S_MUL: begin
        x     <= {mac[31:0], x[127:32]};
        carry <= (cnt[1:0] == 2'd3) ? 32'd0 : mac[63:32];
        cnt   <= cnt + 4'd1;
      end
      S_BETA: begin
        bp <= prod;
      end
      S_SIGN: begin
        x  <= (neg ? ~x : x) + ROUND_HALF + {127'd0, neg};
        bt <= bneg ? (65'd0 - {1'b0, bp}) : {1'b0, bp};
      end
      S_ADD: begin
        x <= x + {{31{bt[64]}}, bt, 32'd0};
      end
      S_SAT: begin
        if (out_free) begin
          res.raw_dot   <= dot_q;
          res.saturated <= !fits;
          if (fits) begin
            res.dequant_out <= x[87:56];
          end else begin
            res.dequant_out <= x[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/int8_dot_product_dequant.sv
// Top level of the INT8 dot product with per-channel fixed-point dequantization.
// Items not marked last are taken one per cycle while the dequantizer is idle: four byte lanes
// multiply in parallel and a merging adder folds their products into the 32-bit accumulator,
// which wraps. An item marked last closes the dot product; the input then stays closed while
// the shared 32x32-bit multiplier runs the twelve limb steps of the 128-bit scale product and
// then the beta term before rounding and saturation. The result waits in an output register,
// and the next dot product is taken while it waits; a stalled output holds back only the end
// of the following last item. alpha_gain and beta_gain are written over the APB port at byte
// addresses 0 and 4; the user must write them only while idle; the block does not enforce it.
`include "int8_dot_product_dequant_defines.svh"

module int8_dot_product_dequant
  import idpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  idpd_in_if.sink     in_ch,
  idpd_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           accept;
  logic           dq_idle;
  logic [31:0]    alpha_gain;
  logic [31:0]    beta_gain;
  logic [31:0]    row_hold;
  logic [31:0]    col_hold;
  logic [31:0]    cprev_hold;
  idpd_dot_stat_t dot_stat;
  idpd_opnd_t     opnd;
  idpd_res_t      res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BETA) ? beta_gain : alpha_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= ALPHA_RESET;
      beta_gain  <= BETA_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_ALPHA: alpha_gain <= pwdata;
        REG_BETA:  beta_gain  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = dq_idle && !dot_stat.pend;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_item) begin
      row_hold   <= in_ch.row_scale;
      col_hold   <= in_ch.col_scale;
      cprev_hold <= in_ch.c_prev;
    end
  end

  idpd_dot u_dot (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .a_pack     (in_ch.a_pack),
    .b_pack     (in_ch.b_pack),
    .lanes_used (in_ch.lanes_used),
    .last_item  (in_ch.last_item),
    .stat       (dot_stat)
  );

  assign opnd.row_scale  = row_hold;
  assign opnd.col_scale  = col_hold;
  assign opnd.c_prev     = cprev_hold;
  assign opnd.alpha_gain = alpha_gain;
  assign opnd.beta_gain  = beta_gain;

  idpd_dequant u_dequant (
    .clk       (clk),
    .rst       (rst),
    .start     (dot_stat.done),
    .dot       (dot_stat.dot),
    .opnd      (opnd),
    .idle      (dq_idle),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.dequant_out = res.dequant_out;
  assign out_ch.raw_dot     = res.raw_dot;
  assign out_ch.saturated   = res.saturated;

  `IDPD_ASSERT_NEXT(a_last_closes_input, clk, rst, accept && in_ch.last_item, !in_ch.ready)
  `IDPD_ASSERT_NOW(a_start_when_idle, clk, rst, dot_stat.done, dq_idle)
  `IDPD_ASSERT_NOW(a_sat_limits, clk, rst, out_ch.valid && out_ch.saturated, (out_ch.dequant_out == 32'sh7FFF_FFFF) || (out_ch.dequant_out == 32'sh8000_0000))

endmodule

FILE: dv/dot_dequant_checker.sv
// Checker that predicts every dequantized result of the block and compares it with the output.
module dot_dequant_checker
  import idpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  idpd_in_if          in_mon,
  idpd_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] alpha_q;
  logic [31:0] beta_q;
  logic [31:0] dot_sum;
  idpd_res_t   dequant_queue[$];
  int          err_count = 0;

  function automatic logic [31:0] lane_sum(input logic [31:0] a, input logic [31:0] b,
                                           input logic [2:0] lanes);
    logic [31:0]        s;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
    logic signed [15:0] p;
    int                 n;
    s = '0;
    n = (lanes > EFF_LANES) ? EFF_LANES : lanes;
    for (int i = 0; i < n; i++) begin
      x = a[8*i +: 8];
      y = b[8*i +: 8];
      p = x * y;
      s = s + 32'(p);
    end
    return s;
  endfunction

  // The exact value carries 72 fraction bits; Q16.16 keeps bits 56 and up.
  function automatic idpd_res_t dequant_predict(input logic [31:0] dot, input logic [31:0] row,
                                                input logic [31:0] col, input logic [31:0] cp);
    logic signed [159:0] term_a;
    logic signed [159:0] term_b;
    logic signed [159:0] rounded;
    logic signed [159:0] top_lim;
    logic signed [159:0] bot_lim;
    idpd_res_t           r;
    top_lim = 160'sd2147483647;
    bot_lim = -160'sd2147483648;
    term_a  = $signed(dot) * $signed({1'b0, row}) * $signed({1'b0, col}) * $signed(alpha_q);
    term_b  = $signed(beta_q) * $signed(cp);
    term_b  = term_b <<< 32;
    rounded = (term_a + term_b + (160'sd1 <<< 55)) >>> 56;
    r.raw_dot = dot;
    if (rounded > top_lim) begin
      r.dequant_out = 32'h7FFF_FFFF;
      r.saturated   = 1'b1;
    end else if (rounded < bot_lim) begin
      r.dequant_out = 32'h8000_0000;
      r.saturated   = 1'b1;
    end else begin
      r.dequant_out = rounded[31:0];
      r.saturated   = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    idpd_res_t got;
    idpd_res_t want;
    if (rst) begin
      alpha_q = ALPHA_RESET;
      beta_q  = BETA_RESET;
      dot_sum = '0;
      dequant_queue.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.dequant_out = out_mon.dequant_out;
        got.raw_dot     = out_mon.raw_dot;
        got.saturated   = out_mon.saturated;
        if (dequant_queue.size() == 0) begin
          $error("unexpected result: dequant_out %0d, raw_dot %0d",
                 $signed(got.dequant_out), $signed(got.raw_dot));
          err_count++;
        end else begin
          want = dequant_queue.pop_front();
          if (got.dequant_out !== want.dequant_out) begin
            $error("dequant_out: expected %0d, got %0d",
                   $signed(want.dequant_out), $signed(got.dequant_out));
            err_count++;
          end
          if (got.raw_dot !== want.raw_dot) begin
            $error("raw_dot: expected %0d, got %0d",
                   $signed(want.raw_dot), $signed(got.raw_dot));
            err_count++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
            err_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_ALPHA: alpha_q = pwdata;
          REG_BETA:  beta_q  = pwdata;
          default: begin
          end
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        dot_sum = dot_sum + lane_sum(in_mon.a_pack, in_mon.b_pack, in_mon.lanes_used);
        if (in_mon.last_item) begin
          dequant_queue.push_back(dequant_predict(dot_sum, in_mon.row_scale, in_mon.col_scale,
                                                  in_mon.c_prev));
          dot_sum = '0;
        end
      end
    end
    errors  <= err_count;
    pending <= dequant_queue.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the testbench: clock, reset, stimulus, output stalls and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import idpd_pkg::*;

  localparam logic [31:0] ONE_Q = 32'h0100_0000;
  localparam int          BATCH = 115;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          items_sent = 0;
  bit          src_pace;

  idpd_in_if  in_ch ();
  idpd_out_if out_ch ();

  int8_dot_product_dequant dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dot_dequant_checker chk (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The output side stalls for a freshly drawn number of cycles before each result.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_item(input logic [31:0] a, input logic [31:0] b, input logic [2:0] lanes,
                           input logic last, input logic [31:0] row, input logic [31:0] col,
                           input logic [31:0] cp);
    int gap;
    gap = src_pace ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.a_pack     <= a;
    in_ch.b_pack     <= b;
    in_ch.lanes_used <= lanes;
    in_ch.last_item  <= last;
    in_ch.row_scale  <= row;
    in_ch.col_scale  <= col;
    in_ch.c_prev     <= cp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] alpha, input logic [31:0] beta);
    settle();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
  endtask

  function automatic logic [31:0] pick_pack();
    case ($urandom_range(0, 5))
      0:       return 32'h8080_8080;
      1:       return 32'h7F7F_7F7F;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000);
  endfunction

  // Mostly short, well-formed dot products; now and then lane counts outside one to four.
  task automatic random_batch();
    int          start;
    int          len;
    logic [2:0]  lanes;
    start = items_sent;
    while (items_sent - start < BATCH) begin
      len = $urandom_range(1, 6);
      src_pace = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len; i++) begin
        lanes = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 4));
        send_item(pick_pack(), pick_pack(), lanes, i == len - 1, pick_scale(), pick_scale(),
                  $urandom);
      end
      items_sent += len;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.a_pack     <= '0;
    in_ch.b_pack     <= '0;
    in_ch.lanes_used <= '0;
    in_ch.last_item  <= 1'b0;
    in_ch.row_scale  <= '0;
    in_ch.col_scale  <= '0;
    in_ch.c_prev     <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    src_pace = 1'b1;
    send_item(32'h7F7F_7F7F, 32'h7F7F_7F7F, 3'd4, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item(32'h8080_8080, 32'h7F7F_7F7F, 3'd4, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item(32'hFFFF_FFFF, 32'h0101_0101, 3'd0, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item($urandom, $urandom, 3'd5, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item($urandom, $urandom, 3'd6, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item($urandom, $urandom, 3'd7, 1'b1, ONE_Q, ONE_Q, 32'h0);
    send_item(32'h8081_7F01, 32'h7F80_01FF, 3'd1, 1'b0, 32'h0, 32'h0, 32'h0);
    send_item(32'h8081_7F01, 32'h7F80_01FF, 3'd2, 1'b0, 32'h0, 32'h0, 32'h0);
    send_item(32'h8081_7F01, 32'h7F80_01FF, 3'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF);
    // Exactly one half below and above zero, to pin down the rounding direction.
    send_item(32'h0000_0001, 32'h0000_0001, 3'd1, 1'b1, 32'h0000_0080, ONE_Q, 32'h0);
    send_item(32'h0000_00FF, 32'h0000_0001, 3'd1, 1'b1, 32'h0000_0080, ONE_Q, 32'h0);
    send_item(32'h7F7F_7F7F, 32'h7F7F_7F7F, 3'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(32'h8080_8080, 32'h7F7F_7F7F, 3'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_item(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b0, ONE_Q, ONE_Q, 32'h0);
    send_item(32'h1234_5678, 32'h9ABC_DEF0, 3'd0, 1'b1, ONE_Q, ONE_Q, 32'h8000_0000);

    random_batch();

    configure(32'h7FFF_FFFF, 32'h8000_0000);
    src_pace = 1'b1;
    send_item(32'h0, 32'h0, 3'd4, 1'b1, 32'h0, 32'h0, 32'h8000_0000);
    send_item(32'h0, 32'h0, 3'd4, 1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_item(32'h8080_8080, 32'h7F7F_7F7F, 3'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h7FFF_FFFF);
    random_batch();

    configure(32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h8080_8080, 32'h8080_8080, 3'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000);
    random_batch();

    configure(32'h0000_0000, ONE_Q);
    random_batch();

    configure(32'hFF00_0000, 32'h0080_0000);
    random_batch();

    configure($urandom, $urandom);
    random_batch();

    configure(32'h0000_0001, 32'hFFFF_FFFF);
    random_batch();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/idpd_pkg.sv
rtl/core/idpd_in_if.sv
rtl/core/idpd_out_if.sv
rtl/core/idpd_lane.sv
rtl/core/idpd_dot.sv
rtl/core/idpd_dequant.sv
rtl/core/int8_dot_product_dequant.sv
dv/dot_dequant_checker.sv
dv/testbench.sv
